@@ hw/rtl/merge_sorter_assert.svh @@
// assertion macros for the merge sorter
// expects signals clk and arst_n in the module that uses them
`ifndef MERGE_SORTER_ASSERT_SVH
`define MERGE_SORTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("merge_sorter: check failed");
`define MS_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("merge_sorter: forbidden condition");
`else
`define MS_ASSERT(label, prop)
`define MS_ASSERT_NEVER(label, cond)
`endif
`endif

@@ hw/rtl/ms_pkg.sv @@
// shared types and constants for the merge sorter
// no dependencies
`timescale 1ns / 1ps

package ms_pkg;

	localparam int DATA_W           = 32;
	localparam int MAX_ELEMENTS_DEF = 64;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     final_res;
	} result_t;

endpackage

@@ hw/rtl/ms_ram.sv @@
// element bank: one write port, two registered write-first read ports
// depends on ms_pkg for the data width
`timescale 1ns / 1ps

module ms_ram #(
	parameter int DEPTH = ms_pkg::MAX_ELEMENTS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [ms_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]             raddr_a,
	input  logic [AW-1:0]             raddr_b,
	output logic [ms_pkg::DATA_W-1:0] rdata_a,
	output logic [ms_pkg::DATA_W-1:0] rdata_b
);
	import ms_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	// a read of the address written at the same edge returns the new data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (we && (waddr == raddr_a)) begin
			rdata_a <= wdata;
		end else begin
			rdata_a <= mem_q[raddr_a];
		end
		if (we && (waddr == raddr_b)) begin
			rdata_b <= wdata;
		end else begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

@@ hw/rtl/merge_sorter.sv @@
// Stable ascending merge sorter for signed 32-bit values. A transfer on the
// input (start high while busy is low) stores one value; the set ends at an
// item with last set, or at the item that fills the store (MAX_ELEMENTS).
// The set is then sorted by bottom-up merge passes that ping-pong between
// two banks, one element written per cycle by a single shared compare and
// select unit, and the sorted values come out one per cycle, each shown for
// exactly one cycle with result_valid high; the last carries final_res.
// The receiver cannot stall the stream. busy is raised by the transfer that
// ends a set and falls in the cycle after the final result. A set of n items
// is loaded, then sorted in ceil(log2 n) merge passes over all n elements,
// then streamed out.
// depends on ms_pkg, ms_ram and merge_sorter_assert.svh
`timescale 1ns / 1ps
`include "merge_sorter_assert.svh"

module merge_sorter #(
	parameter int MAX_ELEMENTS = ms_pkg::MAX_ELEMENTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ms_pkg::item_t   item,
	output logic            result_valid,
	output ms_pkg::result_t result
);
	import ms_pkg::*;

	// address bits for a bank, count bits able to hold MAX_ELEMENTS itself
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_MERGE,
		ST_OUT
	} state_t;

	state_t state_q, state_d;

	// control registers
	logic [CW-1:0] cnt_q, cnt_d;       // items loaded so far
	logic [CW-1:0] n_q, n_d;           // size of the set being sorted
	logic [CW-1:0] width_q, width_d;   // run length of the current pass
	logic [CW-1:0] left_q, left_d;     // left run head, also output index
	logic [CW-1:0] right_q, right_d;   // right run head
	logic [CW-1:0] mid_q, mid_d;       // end of left run
	logic [CW-1:0] hi_q, hi_d;         // end of right run
	logic [CW-1:0] dst_q, dst_d;       // write pointer in the other bank
	logic          src_q, src_d;       // bank holding the current runs

	// run-pair setup request
	logic          new_pair;
	logic [CW-1:0] pair_lo;
	logic [CW-1:0] pair_w;
	logic [CW-1:0] pair_n;
	logic [CW:0]   width_x2;

	// bank ports
	logic              we0, we1;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [AW-1:0]     raddr_a, raddr_b;
	logic [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
	logic signed [DATA_W-1:0] head_a, head_b;
	logic          take_left;

	// lo + span, clamped to the set size
	function automatic logic [CW-1:0] clamp_add(
		input logic [CW-1:0] lo,
		input logic [CW:0]   span,
		input logic [CW-1:0] n
	);
		logic [CW:0] sum;
		sum = {1'b0, lo} + span;
		if (sum > {1'b0, n}) begin
			return n;
		end
		return sum[CW-1:0];
	endfunction

	ms_ram #(
		.DEPTH(MAX_ELEMENTS),
		.AW   (AW)
	) u_bank0 (
		.clk    (clk),
		.we     (we0),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rd0_a),
		.rdata_b(rd0_b)
	);

	ms_ram #(
		.DEPTH(MAX_ELEMENTS),
		.AW   (AW)
	) u_bank1 (
		.clk    (clk),
		.we     (we1),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rd1_a),
		.rdata_b(rd1_b)
	);

	// the read data always belongs to the registered run heads
	assign head_a = src_q ? rd1_a : rd0_a;
	assign head_b = src_q ? rd1_b : rd0_b;

	// shared compare: left wins ties, exhausted runs never win
	assign take_left = (left_q != mid_q) && ((right_q == hi_q) || (head_a <= head_b));

	assign width_x2 = {width_q, 1'b0};

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		n_d      = n_q;
		width_d  = width_q;
		left_d   = left_q;
		right_d  = right_q;
		mid_d    = mid_q;
		hi_d     = hi_q;
		dst_d    = dst_q;
		src_d    = src_q;
		we0      = 1'b0;
		we1      = 1'b0;
		waddr    = dst_q[AW-1:0];
		wdata    = take_left ? head_a : head_b;
		new_pair = 1'b0;
		pair_lo  = '0;
		pair_w   = width_q;
		pair_n   = n_q;

		case (state_q)
			ST_LOAD: begin
				if (start) begin
					we0   = 1'b1;
					waddr = cnt_q[AW-1:0];
					wdata = item.value;
					cnt_d = cnt_q + 1'b1;
					if (item.last || (cnt_q + 1'b1 == CW'(MAX_ELEMENTS))) begin
						cnt_d = '0;
						n_d   = cnt_q + 1'b1;
						src_d = 1'b0;
						if (cnt_q == '0) begin
							// single element: nothing to merge
							left_d  = '0;
							state_d = ST_OUT;
						end else begin
							width_d  = CW'(1);
							new_pair = 1'b1;
							pair_lo  = '0;
							pair_w   = CW'(1);
							pair_n   = cnt_q + 1'b1;
							state_d  = ST_MERGE;
						end
					end
				end
			end

			ST_MERGE: begin
				we0   = src_q;
				we1   = !src_q;
				dst_d = dst_q + 1'b1;
				if (take_left) begin
					left_d = left_q + 1'b1;
				end else begin
					right_d = right_q + 1'b1;
				end
				if (dst_q + 1'b1 == hi_q) begin
					if (hi_q == n_q) begin
						// pass done: result now sits in the other bank
						src_d = !src_q;
						if (width_x2 >= {1'b0, n_q}) begin
							left_d  = '0;
							state_d = ST_OUT;
						end else begin
							width_d  = width_x2[CW-1:0];
							new_pair = 1'b1;
							pair_lo  = '0;
							pair_w   = width_x2[CW-1:0];
						end
					end else begin
						new_pair = 1'b1;
						pair_lo  = hi_q;
					end
				end
			end

			ST_OUT: begin
				left_d = left_q + 1'b1;
				if (left_q == n_q - 1'b1) begin
					state_d = ST_LOAD;
				end
			end

			default: begin
				state_d = ST_LOAD;
			end
		endcase

		// set up the next pair of runs; a lone tail is a left run with empty right
		if (new_pair) begin
			dst_d   = pair_lo;
			left_d  = pair_lo;
			mid_d   = clamp_add(pair_lo, {1'b0, pair_w}, pair_n);
			hi_d    = clamp_add(pair_lo, {pair_w, 1'b0}, pair_n);
			right_d = mid_d;
		end
	end

	// reads are issued for the next heads so the data lands with the pointers
	assign raddr_a = left_d[AW-1:0];
	assign raddr_b = right_d[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			n_q     <= '0;
			width_q <= '0;
			left_q  <= '0;
			right_q <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			dst_q   <= '0;
			src_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			n_q     <= n_d;
			width_q <= width_d;
			left_q  <= left_d;
			right_q <= right_d;
			mid_q   <= mid_d;
			hi_q    <= hi_d;
			dst_q   <= dst_d;
			src_q   <= src_d;
		end
	end

	// output stream comes straight from the registered bank read
	assign busy                = (state_q != ST_LOAD);
	assign result_valid        = (state_q == ST_OUT);
	assign result.sorted_value = head_a;
	assign result.final_res    = (state_q == ST_OUT) && (left_q == n_q - 1'b1);

	// checks
	`MS_ASSERT(a_merge_in_range, (state_q == ST_MERGE) |-> ((dst_q < hi_q) && (hi_q <= n_q)))
	`MS_ASSERT(a_merge_heads, (state_q == ST_MERGE) |-> ((left_q <= mid_q) && (right_q <= hi_q)))
	`MS_ASSERT(a_final_frees, (result_valid && result.final_res) |=> !busy)
	`MS_ASSERT(a_out_index, result_valid |-> (left_q < n_q))
	`MS_ASSERT_NEVER(a_load_overrun, (state_q == ST_LOAD) && (cnt_q >= CW'(MAX_ELEMENTS)))

endmodule

@@ tb/tb_merge_sorter.sv @@
`timescale 1ns / 1ps
// self-checking testbench for merge_sorter: loads sets of signed values and checks the
// sorted stream against a stable insertion sort kept in the testbench
// depends on ms_pkg and merge_sorter

module tb_merge_sorter;
	import ms_pkg::*;

	localparam int SET_CAP      = MAX_ELEMENTS_DEF;
	// a full set is merged with no transfer and no result at all, so this is ample
	localparam int STALL_LIMIT  = 4000;
	localparam int TARGET_ITEMS = 330;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    result_valid;
	result_t result;

	// values of the set being loaded, and the sorted values still to come out
	logic signed [DATA_W-1:0] open_set[$];
	result_t                  sorted_stream[$];

	int error_count  = 0;
	int items_sent   = 0;
	int idle_pct     = 0;
	int quiet_cycles = 0;

	merge_sorter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		error_count++;
	endtask

	// stable ascending sort of the closed set: a new value goes after every equal one
	function automatic void release_sorted_set();
		logic signed [DATA_W-1:0] ordered[$];
		logic signed [DATA_W-1:0] v;
		int pos;
		result_t r;
		foreach (open_set[i]) begin
			v   = open_set[i];
			pos = ordered.size();
			while (pos > 0 && ordered[pos-1] > v)
				pos--;
			ordered.insert(pos, v);
		end
		foreach (ordered[i]) begin
			r.sorted_value = ordered[i];
			r.final_res    = (i == ordered.size() - 1);
			sorted_stream.push_back(r);
		end
		open_set.delete();
	endfunction

	// one process samples both sides at the rising edge; DUT outputs still hold
	// the values of the cycle that this edge ends
	always @(posedge clk) begin : stream_monitor
		result_t want;
		logic    took_item;
		if (arst_n) begin
			took_item = start && !busy;
			// a result can never belong to the set closed at this same edge,
			// so checking before predicting is safe
			if (result_valid) begin
				if (sorted_stream.size() == 0) begin
					report_mismatch($sformatf("unexpected result value %0d final %0b",
						result.sorted_value, result.final_res));
				end else begin
					want = sorted_stream.pop_front();
					if (result.sorted_value !== want.sorted_value)
						report_mismatch($sformatf("sorted_value %0d, expected %0d",
							result.sorted_value, want.sorted_value));
					if (result.final_res !== want.final_res)
						report_mismatch($sformatf("final_res %0b, expected %0b at value %0d",
							result.final_res, want.final_res, want.sorted_value));
				end
			end
			if (took_item) begin
				open_set.push_back(item.value);
				// the set closes on last, or on the transfer that fills the store
				if (item.last || open_set.size() == SET_CAP)
					release_sorted_set();
			end
			// watchdog: cycles with neither an input transfer nor a result
			if (took_item || result_valid)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("merge_sorter test failed");
				$finish;
			end
		end
	end

	// one input transfer; start is left high so back-to-back items need no toggle
	task automatic send_element(input logic signed [DATA_W-1:0] v, input logic lst);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item  <= '{value: v, last: lst};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	// hold off the sender until the block has emptied its output stream
	task automatic pause_until_drained();
		@(negedge clk);
		start <= 1'b0;
		while (sorted_stream.size() != 0 || busy)
			@(negedge clk);
	endtask

	// half full-range values, the rest clusters that force duplicates and the extremes
	function automatic logic signed [DATA_W-1:0] random_element();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return $urandom;
			5, 6:          return $signed(32'($urandom_range(6))) - 3;
			7: begin
				case ($urandom_range(3))
					0:       return 32'sh8000_0000;
					1:       return 32'sh7fff_ffff;
					2:       return 0;
					default: return -1;
				endcase
			end
			default:       return $signed(32'($urandom_range(2000))) - 1000;
		endcase
	endfunction

	task automatic send_set(input int len, input logic close_with_last);
		for (int i = 0; i < len; i++)
			send_element(random_element(), (i == len - 1) ? close_with_last : 1'b0);
	endtask

	// single-element sets at both extremes and at zero
	task automatic test_single_element();
		send_element(32'sh8000_0000, 1'b1);
		send_element(32'sh7fff_ffff, 1'b1);
		send_element(0, 1'b1);
	endtask

	// extremes, signs around zero and repeated keys within one set
	task automatic test_extreme_mix();
		logic signed [DATA_W-1:0] vals[10];
		vals = '{32'sh7fff_ffff, 32'sh8000_0000, -1, 0, 1,
			32'sh8000_0000, 32'sh7fff_ffff, 5, 5, -5};
		foreach (vals[i])
			send_element(vals[i], i == 9);
	endtask

	// a short set made only of two repeated keys, already in descending order
	task automatic test_duplicate_keys();
		send_element(3, 1'b0);
		send_element(3, 1'b0);
		send_element(3, 1'b0);
		send_element(-3, 1'b0);
		send_element(-3, 1'b1);
	endtask

	// a full store closes the set with or without last on the final transfer
	task automatic test_store_fill(input logic close_with_last);
		send_set(SET_CAP, close_with_last);
	endtask

	// random sets, mostly short, now and then medium or full, up to an item count
	task automatic test_random_sets(input int pct, input int item_goal);
		int pick;
		idle_pct = pct;
		while (items_sent < item_goal) begin
			pick = $urandom_range(19);
			if (pick == 0)
				send_set(SET_CAP, 1'($urandom_range(1)));
			else if (pick <= 2)
				send_set($urandom_range(40, 13), 1'b1);
			else
				send_set($urandom_range(10, 1), 1'b1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		idle_pct = 0;
		test_single_element();
		test_extreme_mix();
		test_duplicate_keys();
		test_store_fill(1'b0);
		test_random_sets(0, 130);

		// sender waits until the whole stream is out before the next phase
		pause_until_drained();
		test_random_sets(46, 240);
		test_store_fill(1'b1);
		test_random_sets(8, TARGET_ITEMS);

		@(negedge clk);
		start <= 1'b0;
		while (sorted_stream.size() != 0)
			@(negedge clk);
		// keep watching for stray results after the last expected one
		repeat (20) @(posedge clk);

		if (error_count == 0)
			$display("merge_sorter test passed");
		else
			$display("merge_sorter test failed");
		$finish;
	end

endmodule
